// ===== src/dvru_pkg.sv =====
// ----------------------------------------------------------------------------
// dvru_pkg
// Shared types, widths and helpers for the distance-vector route update core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dvru_pkg;

   localparam int TBL_DEPTH = 256;
   localparam int ADDR_W    = $clog2(TBL_DEPTH);
   localparam int DEST_W    = 8;
   localparam int HOP_W     = 8;
   localparam int COST_W    = 5;
   localparam int COUNT_W   = 9;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 8;

   localparam logic [COST_W-1:0] COST_INF = COST_W'(16);
   localparam logic [COST_W-1:0] LINK_COST_RESET = COST_W'(1);

   localparam logic [CSR_IDX_W-1:0] CSR_NEIGHBOR_ID = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINK_COST   = 1'b1;

   typedef enum logic [1:0] {
      REQ_LOAD      = 2'd0,
      REQ_ADVERTISE = 2'd1,
      REQ_READ      = 2'd2
   } req_code_type;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [DEST_W-1:0] dest_id;
      logic [HOP_W-1:0]  hop_id;
      logic [COST_W-1:0] cost_in;
   } req_item_type;

   typedef struct packed {
      logic [HOP_W-1:0]  gw_hop;
      logic [COST_W-1:0] cost;
   } route_entry_type;

   typedef struct packed {
      logic            wr_en;       // entry is written back
      logic            count_inc;   // entry goes from empty to valid
      logic            entry_valid;
      route_entry_type entry;
   } route_update_type;

   // Clamp a cost to the unreachable value.
   function automatic logic [COST_W-1:0] sat_cost(input logic [COST_W:0] c);
      logic [COST_W-1:0] r;
      if (c > {1'b0, COST_INF}) begin
         r = COST_INF;
      end else begin
         r = c[COST_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== src/distance_vector_route_update_core.sv =====
// ----------------------------------------------------------------------------
// distance_vector_route_update_core
// Route table keeping next hop and cost per destination id.
//
// Requests arrive on the req_ stream: tuser carries the request kind (load a
// local route, apply a neighbor advertisement, read an entry), tdata carries
// destination, next hop and cost. Every transaction yields exactly one
// response on the rsp_ stream describing the entry after the request and the
// count of valid routes. The user sets the neighbor id and link cost through
// the csr_ write port only while no request is in flight; it is not enforced.
// Throughput: one request per cycle unless the receiver stalls. A request
// passes the update stage register, then the response register. The store is
// read on accept and written back from the update stage; a back-to-back request to
// the same destination takes the written entry from a forwarding register.
// When the receiver stalls, the response register holds, the request in the
// update stage waits, and req_tready drops until the response drains.
// Reset clears all valid marks and the route count at once (no clearing
// pass), sets the neighbor id to 0 and the link cost to 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module distance_vector_route_update_core
   import dvru_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,   // dest_id[7:0], hop_id[15:8], cost_in[20:16]
   input  logic [1:0]            req_tuser,   // req_type[1:0]
   // response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,   // next-hop id[7:0], cost_out[12:8],
                                              // route_count[21:13]
   output logic [0:0]            rsp_tuser,   // entry_valid[0]
   // configuration write port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [HOP_W-1:0]     neighbor_ff;
   logic [COST_W-1:0]    link_cost_ff;
   logic [TBL_DEPTH-1:0] route_valid_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic [COUNT_W-1:0]   count_in;

   logic                 s1_valid_ff;
   req_item_type         s1_item_ff;
   logic                 fwd_hit_ff;
   route_entry_type      fwd_entry_ff;

   logic                 rsp_valid_ff;
   logic                 rsp_entry_valid_ff;
   route_entry_type      rsp_entry_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;

   req_item_type         req_item;
   logic                 req_fire;
   logic                 s1_fire;
   logic                 fwd_hit_in;
   route_entry_type      mem_rd_data;
   route_entry_type      old_entry;
   logic                 old_valid;
   route_update_type     upd;
   route_entry_type      rsp_entry_in;

   assign req_item.req_type = req_tuser;
   assign req_item.dest_id  = req_tdata[7:0];
   assign req_item.hop_id   = req_tdata[15:8];
   assign req_item.cost_in  = req_tdata[20:16];

   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_fire   = req_tvalid && req_tready;

   dvru_route_mem u_mem (
      .clock   (clock),
      .wr_en   (s1_fire && upd.wr_en),
      .wr_addr (s1_item_ff.dest_id[ADDR_W-1:0]),
      .wr_data (upd.entry),
      .rd_en   (req_fire),
      .rd_addr (req_item.dest_id[ADDR_W-1:0]),
      .rd_data (mem_rd_data)
   );

   // the store returns stale data when the entry is written on the read edge
   assign old_entry = fwd_hit_ff ? fwd_entry_ff : mem_rd_data;
   assign old_valid = route_valid_ff[s1_item_ff.dest_id[ADDR_W-1:0]];

   dvru_update_logic u_upd (
      .item        (s1_item_ff),
      .old_valid   (old_valid),
      .old_entry   (old_entry),
      .neighbor_id (neighbor_ff),
      .link_cost   (link_cost_ff),
      .upd         (upd)
   );

   assign count_in   = count_ff + COUNT_W'(upd.count_inc);
   assign fwd_hit_in = s1_fire && upd.wr_en && (req_item.dest_id == s1_item_ff.dest_id);

   always_comb begin
      if (upd.entry_valid) begin
         rsp_entry_in = upd.entry;
      end else begin
         rsp_entry_in.gw_hop = '0;
         rsp_entry_in.cost   = COST_INF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         neighbor_ff  <= '0;
         link_cost_ff <= LINK_COST_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_NEIGHBOR_ID: neighbor_ff  <= csr_wdata[HOP_W-1:0];
            CSR_LINK_COST:   link_cost_ff <= csr_wdata[COST_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         fwd_hit_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         route_valid_ff <= '0;
         count_ff       <= '0;
      end else begin
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
            fwd_hit_ff  <= fwd_hit_in;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end

         if (s1_fire) begin
            rsp_valid_ff <= 1'b1;
            count_ff     <= count_in;
            if (upd.wr_en) begin
               route_valid_ff[s1_item_ff.dest_id[ADDR_W-1:0]] <= 1'b1;
            end
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff   <= req_item;
         fwd_entry_ff <= upd.entry;
      end
      if (s1_fire) begin
         rsp_entry_valid_ff <= upd.entry_valid;
         rsp_entry_ff       <= rsp_entry_in;
         rsp_count_ff       <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_count_ff, rsp_entry_ff.cost, rsp_entry_ff.gw_hop};
   assign rsp_tuser  = rsp_entry_valid_ff;

endmodule

// ===== src/dvru_route_mem.sv =====
// ----------------------------------------------------------------------------
// dvru_route_mem
// Route entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dvru_route_mem
   import dvru_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  route_entry_type   wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output route_entry_type   rd_data
);

   route_entry_type mem [TBL_DEPTH];
   route_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/dvru_update_logic.sv =====
// ----------------------------------------------------------------------------
// dvru_update_logic
// Decides the new state of one route entry from the request and old entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dvru_update_logic
   import dvru_pkg::*;
(
   input  req_item_type      item,
   input  logic              old_valid,
   input  route_entry_type   old_entry,
   input  logic [HOP_W-1:0]  neighbor_id,
   input  logic [COST_W-1:0] link_cost,
   output route_update_type  upd
);

   logic [COST_W-1:0] cost_sat;
   logic [COST_W-1:0] via_cost;
   route_entry_type   new_entry;
   logic              wr_en;

   assign cost_sat = sat_cost({1'b0, item.cost_in});
   assign via_cost = sat_cost({1'b0, cost_sat} + {1'b0, link_cost});

   always_comb begin
      new_entry = old_entry;
      wr_en     = 1'b0;
      unique case (item.req_type)
         REQ_LOAD: begin
            wr_en            = 1'b1;
            new_entry.gw_hop = item.hop_id;
            new_entry.cost   = cost_sat;
         end
         REQ_ADVERTISE: begin
            // fill empty, refresh same next hop, else replace on lower cost
            if (!old_valid || (old_entry.gw_hop == neighbor_id)
                || (via_cost < old_entry.cost)) begin
               wr_en            = 1'b1;
               new_entry.gw_hop = neighbor_id;
               new_entry.cost   = via_cost;
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   assign upd.wr_en       = wr_en;
   assign upd.count_inc   = wr_en && !old_valid;
   assign upd.entry_valid = wr_en || old_valid;
   assign upd.entry       = new_entry;

endmodule
